FILE: rtl/spsl_pkg.sv
// ----------------------------------------------------------------------------
// spsl_pkg
// Shared types and constants of the speed profile slew limiter.
// ----------------------------------------------------------------------------
package spsl_pkg;

  localparam int unsigned CFG_DATA_W  = 16;
  localparam int unsigned CFG_INDEX_W = 3;

  localparam logic [CFG_INDEX_W-1:0] CFG_SPEED_MAX    = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SPEED_MIN    = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_ACCEL_STEP   = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_DECEL_STEP   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_TURN_STEP    = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_CURVE_GAIN   = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] CFG_OFFSET_GAIN  = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] CFG_HEADING_GAIN = 3'd7;

  localparam logic [14:0] RST_SPEED_MAX    = 15'd2048;
  localparam logic [14:0] RST_SPEED_MIN    = 15'd410;
  localparam logic [14:0] RST_ACCEL_STEP   = 15'd164;
  localparam logic [14:0] RST_DECEL_STEP   = 15'd328;
  localparam logic [14:0] RST_TURN_STEP    = 15'd164;
  localparam logic [15:0] RST_CURVE_GAIN   = 16'd1229;
  localparam logic [15:0] RST_OFFSET_GAIN  = 16'd2048;
  localparam logic [15:0] RST_HEADING_GAIN = 16'd819;

  localparam logic signed [15:0] TURN_STOP_BAND = 16'sd41;

  typedef struct packed {
    logic signed [15:0] req_speed;
    logic signed [15:0] req_turn;
    logic               line_seen;
    logic signed [15:0] curvature;
    logic signed [15:0] lateral_offset;
    logic signed [15:0] heading_offset;
  } in_item_t;

  typedef struct packed {
    logic [14:0]        speed_out;
    logic signed [15:0] turn_out;
  } out_item_t;

  typedef struct packed {
    logic [14:0] speed_max;
    logic [14:0] speed_min;
    logic [14:0] accel_step;
    logic [14:0] decel_step;
    logic [14:0] turn_step;
    logic [15:0] curve_gain;
    logic [15:0] offset_gain;
    logic [15:0] heading_gain;
  } cfg_t;

  typedef struct packed {
    logic [14:0]        target;
    logic signed [15:0] req_turn;
    logic               stop_speed;
    logic               stop_turn;
  } job_t;

endpackage

FILE: rtl/spsl_queue.sv
// ----------------------------------------------------------------------------
// spsl_queue
// Small synchronous FIFO used between the front and back and on the results.
// ----------------------------------------------------------------------------
module spsl_queue #(
  parameter int unsigned DW    = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  logic [DW-1:0] wdata,
  output logic          full,
  input  logic          pop,
  output logic [DW-1:0] rdata,
  output logic          empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

  logic [DW-1:0]    mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CNT_FULL);
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

FILE: rtl/spsl_front.sv
// ----------------------------------------------------------------------------
// spsl_front
// Accepts control ticks, weighs the line errors and forms the speed target.
// ----------------------------------------------------------------------------
module spsl_front (
  input  logic              clk,
  input  logic              rst_n,
  input  spsl_pkg::cfg_t    cfg,
  input  logic              in_push,
  input  spsl_pkg::in_item_t in_item,
  output logic              in_full,
  output logic              job_push,
  output spsl_pkg::job_t    job,
  input  logic              job_full
);
  import spsl_pkg::*;

  logic               valid_r, valid_nxt;
  logic               advance, accept;
  logic signed [15:0] rv_r, rw_r;
  logic [19:0]        term_c_r, term_e_r, term_h_r;

  logic [15:0]        abs_c, abs_e, abs_h;
  logic [31:0]        prod_c, prod_e, prod_h;
  logic [21:0]        slow_sum;
  logic signed [23:0] raw_target, rv_ext, pick_target;
  logic signed [23:0] min_ext, max_ext;
  logic [14:0]        target;

  assign advance  = !valid_r || !job_full;
  assign in_full  = !advance;
  assign accept   = in_push && advance;
  assign job_push = valid_r && !job_full;

  assign abs_c  = in_item.curvature[15]      ? 16'(-in_item.curvature)      : in_item.curvature;
  assign abs_e  = in_item.lateral_offset[15] ? 16'(-in_item.lateral_offset) : in_item.lateral_offset;
  assign abs_h  = in_item.heading_offset[15] ? 16'(-in_item.heading_offset) : in_item.heading_offset;
  assign prod_c = 32'(cfg.curve_gain)   * 32'(abs_c);
  assign prod_e = 32'(cfg.offset_gain)  * 32'(abs_e);
  assign prod_h = 32'(cfg.heading_gain) * 32'(abs_h);

  always_comb begin
    valid_nxt = advance ? in_push : valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rv_r     <= in_item.req_speed;
      rw_r     <= in_item.req_turn;
      term_c_r <= in_item.line_seen ? prod_c[31:12] : '0;
      term_e_r <= in_item.line_seen ? prod_e[31:12] : '0;
      term_h_r <= in_item.line_seen ? prod_h[31:12] : '0;
    end
  end

  always_comb begin
    slow_sum   = 22'(term_c_r) + 22'(term_e_r) + 22'(term_h_r);
    raw_target = signed'({9'd0, cfg.speed_max}) - signed'({2'd0, slow_sum});
    rv_ext     = 24'(rv_r);
    min_ext    = signed'({9'd0, cfg.speed_min});
    max_ext    = signed'({9'd0, cfg.speed_max});
    pick_target = (!rv_r[15] && (rv_ext < raw_target)) ? rv_ext : raw_target;
    if (pick_target < min_ext) begin
      pick_target = min_ext;
    end
    if (pick_target > max_ext) begin
      pick_target = max_ext;
    end
    target = pick_target[14:0];
  end

  always_comb begin
    job.target     = target;
    job.req_turn   = rw_r;
    job.stop_speed = rv_r[15] || (rv_r == 16'sd0);
    job.stop_turn  = (rw_r > -TURN_STOP_BAND) && (rw_r < TURN_STOP_BAND);
  end

endmodule

FILE: rtl/spsl_back.sv
// ----------------------------------------------------------------------------
// spsl_back
// Slews held speed and turn toward queued targets; stop flags can zero them.
// ----------------------------------------------------------------------------
module spsl_back (
  input  logic                clk,
  input  logic                rst_n,
  input  spsl_pkg::cfg_t      cfg,
  input  logic                job_empty,
  input  spsl_pkg::job_t      job,
  output logic                job_pop,
  input  logic                res_full,
  output logic                res_push,
  output spsl_pkg::out_item_t res
);
  import spsl_pkg::*;

  logic [14:0]        speed_now_r, speed_now_nxt;
  logic signed [15:0] turn_now_r, turn_now_nxt;

  logic [14:0]        step;
  logic signed [15:0] step_s, dv_diff, dv;
  logic signed [16:0] spd_sum;
  logic [14:0]        spd_lim;
  logic signed [16:0] ts_s, dw_diff, dw;
  logic signed [17:0] turn_sum;
  logic signed [15:0] turn_sat;

  assign job_pop  = !job_empty && !res_full;
  assign res_push = job_pop;

  always_comb begin
    step    = (job.target < speed_now_r) ? cfg.decel_step : cfg.accel_step;
    step_s  = signed'({1'b0, step});
    dv_diff = signed'({1'b0, job.target}) - signed'({1'b0, speed_now_r});
    if (dv_diff > step_s) begin
      dv = step_s;
    end else if (dv_diff < -step_s) begin
      dv = -step_s;
    end else begin
      dv = dv_diff;
    end
    spd_sum = signed'({2'b0, speed_now_r}) + 17'(dv);
    if (spd_sum < 17'sd0) begin
      spd_lim = '0;
    end else if (spd_sum > signed'({2'b0, cfg.speed_max})) begin
      spd_lim = cfg.speed_max;
    end else begin
      spd_lim = spd_sum[14:0];
    end

    ts_s    = signed'({2'b0, cfg.turn_step});
    dw_diff = 17'(job.req_turn) - 17'(turn_now_r);
    if (dw_diff > ts_s) begin
      dw = ts_s;
    end else if (dw_diff < -ts_s) begin
      dw = -ts_s;
    end else begin
      dw = dw_diff;
    end
    turn_sum = 18'(turn_now_r) + 18'(dw);
    if (turn_sum > 18'sd32767) begin
      turn_sat = 16'sh7FFF;
    end else if (turn_sum < -18'sd32768) begin
      turn_sat = 16'sh8000;
    end else begin
      turn_sat = turn_sum[15:0];
    end

    speed_now_nxt = job.stop_speed ? '0 : spd_lim;
    turn_now_nxt  = (job.stop_speed && job.stop_turn) ? '0 : turn_sat;

    res.speed_out = speed_now_nxt;
    res.turn_out  = turn_now_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_now_r <= '0;
      turn_now_r  <= '0;
    end else if (job_pop) begin
      speed_now_r <= speed_now_nxt;
      turn_now_r  <= turn_now_nxt;
    end
  end

endmodule

FILE: rtl/speed_profile_slew_limiter.sv
// ----------------------------------------------------------------------------
// speed_profile_slew_limiter
// Path: front-end registers, mid queue, back-end state update, output queue.
// Throughput: one transaction per cycle while results are popped, set by the
// back-end update; the multiply stage and both queues are fully pipelined.
// Reset: held speed and turn rate go to zero, registers to their defaults,
// and both queues empty.
// ----------------------------------------------------------------------------
module speed_profile_slew_limiter #(
  parameter int unsigned MID_DEPTH = 2,
  parameter int unsigned OUT_DEPTH = 2
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_push,
  input  spsl_pkg::in_item_t                   in_item,
  output logic                                 in_full,
  output logic                                 out_empty,
  input  logic                                 out_pop,
  output spsl_pkg::out_item_t                  out_item,
  input  logic                                 cfg_we,
  input  logic [spsl_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [spsl_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
  import spsl_pkg::*;

  cfg_t      cfg_r, cfg_nxt;
  logic      job_push, job_full, job_empty, job_pop;
  job_t      job_in, job_out;
  logic      res_push, res_full;
  out_item_t res;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_SPEED_MAX:    cfg_nxt.speed_max    = cfg_wdata[14:0];
        CFG_SPEED_MIN:    cfg_nxt.speed_min    = cfg_wdata[14:0];
        CFG_ACCEL_STEP:   cfg_nxt.accel_step   = cfg_wdata[14:0];
        CFG_DECEL_STEP:   cfg_nxt.decel_step   = cfg_wdata[14:0];
        CFG_TURN_STEP:    cfg_nxt.turn_step    = cfg_wdata[14:0];
        CFG_CURVE_GAIN:   cfg_nxt.curve_gain   = cfg_wdata;
        CFG_OFFSET_GAIN:  cfg_nxt.offset_gain  = cfg_wdata;
        CFG_HEADING_GAIN: cfg_nxt.heading_gain = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.speed_max    <= RST_SPEED_MAX;
      cfg_r.speed_min    <= RST_SPEED_MIN;
      cfg_r.accel_step   <= RST_ACCEL_STEP;
      cfg_r.decel_step   <= RST_DECEL_STEP;
      cfg_r.turn_step    <= RST_TURN_STEP;
      cfg_r.curve_gain   <= RST_CURVE_GAIN;
      cfg_r.offset_gain  <= RST_OFFSET_GAIN;
      cfg_r.heading_gain <= RST_HEADING_GAIN;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  spsl_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_push  (in_push),
    .in_item  (in_item),
    .in_full  (in_full),
    .job_push (job_push),
    .job      (job_in),
    .job_full (job_full)
  );

  spsl_queue #(
    .DW    ($bits(job_t)),
    .DEPTH (MID_DEPTH)
  ) u_mid_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (job_push),
    .wdata (job_in),
    .full  (job_full),
    .pop   (job_pop),
    .rdata (job_out),
    .empty (job_empty)
  );

  spsl_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .job_empty (job_empty),
    .job       (job_out),
    .job_pop   (job_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res)
  );

  spsl_queue #(
    .DW    ($bits(out_item_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res),
    .full  (res_full),
    .pop   (out_pop),
    .rdata (out_item),
    .empty (out_empty)
  );

  a_speed_within_max: assert property (
    @(posedge clk) disable iff (!rst_n)
    !out_empty |-> (out_item.speed_out <= cfg_r.speed_max)
  ) else $error("speed result above speed_max");

  a_stall_needs_results: assert property (
    @(posedge clk) disable iff (!rst_n)
    in_full |-> (job_full && !out_empty)
  ) else $error("front stalled with no backlog behind it");

  a_ready_after_reset: assert property (
    @(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> (!in_full && out_empty)
  ) else $error("queues not empty after reset");

endmodule

FILE: dv/spsl_command_checker.sv
// ----------------------------------------------------------------------------
// spsl_command_checker
// Watches the tick and command channels of the speed profile slew limiter,
// mirrors its registers and held speed and turn rate, predicts the command
// for every accepted tick and compares it with each popped command.
// ----------------------------------------------------------------------------
module spsl_command_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_push,
  input  logic                             in_full,
  input  spsl_pkg::in_item_t               in_item,
  input  logic                             out_empty,
  input  logic                             out_pop,
  input  spsl_pkg::out_item_t              out_item,
  input  logic                             cfg_we,
  input  logic [spsl_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [spsl_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output int                               err_count,
  output int                               pending
);
  import spsl_pkg::*;

  cfg_t      limits;
  longint    held_speed;
  longint    held_turn;
  out_item_t pending_cmds[$];
  out_item_t want;

  function automatic longint mag(input longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic longint clip(input longint v, input longint lo, input longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic out_item_t next_command(input in_item_t tick);
    longint    vmax;
    longint    goal;
    longint    lim;
    longint    rv;
    longint    rw;
    out_item_t cmd;
    rv   = longint'(tick.req_speed);
    rw   = longint'(tick.req_turn);
    vmax = longint'(limits.speed_max);
    goal = vmax;
    if (tick.line_seen) begin
      goal = vmax
           - ((longint'(limits.curve_gain) * mag(longint'(tick.curvature))) >>> 12)
           - ((longint'(limits.offset_gain) * mag(longint'(tick.lateral_offset))) >>> 12)
           - ((longint'(limits.heading_gain) * mag(longint'(tick.heading_offset))) >>> 12);
    end
    if (rv < goal && rv >= 0) goal = rv;
    if (goal < longint'(limits.speed_min)) goal = longint'(limits.speed_min);
    if (goal > vmax) goal = vmax;
    lim = (goal < held_speed) ? longint'(limits.decel_step) : longint'(limits.accel_step);
    held_speed = clip(held_speed + clip(goal - held_speed, -lim, lim), 0, vmax);
    lim = longint'(limits.turn_step);
    held_turn = clip(held_turn + clip(rw - held_turn, -lim, lim), -32768, 32767);
    if (rv <= 0) begin
      held_speed = 0;
      if (mag(rw) < longint'(TURN_STOP_BAND)) held_turn = 0;
    end
    cmd.speed_out = held_speed[14:0];
    cmd.turn_out  = held_turn[15:0];
    return cmd;
  endfunction

  task automatic report(input string msg);
    if (err_count < 40) $display("spsl_command_checker: %s", msg);
    err_count++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      limits.speed_max    = RST_SPEED_MAX;
      limits.speed_min    = RST_SPEED_MIN;
      limits.accel_step   = RST_ACCEL_STEP;
      limits.decel_step   = RST_DECEL_STEP;
      limits.turn_step    = RST_TURN_STEP;
      limits.curve_gain   = RST_CURVE_GAIN;
      limits.offset_gain  = RST_OFFSET_GAIN;
      limits.heading_gain = RST_HEADING_GAIN;
      held_speed = 0;
      held_turn  = 0;
      pending_cmds.delete();
      err_count = 0;
      pending   = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_SPEED_MAX:    limits.speed_max    = cfg_wdata[14:0];
          CFG_SPEED_MIN:    limits.speed_min    = cfg_wdata[14:0];
          CFG_ACCEL_STEP:   limits.accel_step   = cfg_wdata[14:0];
          CFG_DECEL_STEP:   limits.decel_step   = cfg_wdata[14:0];
          CFG_TURN_STEP:    limits.turn_step    = cfg_wdata[14:0];
          CFG_CURVE_GAIN:   limits.curve_gain   = cfg_wdata;
          CFG_OFFSET_GAIN:  limits.offset_gain  = cfg_wdata;
          CFG_HEADING_GAIN: limits.heading_gain = cfg_wdata;
          default: ;
        endcase
      end
      if (in_push && !in_full) pending_cmds.push_back(next_command(in_item));
      if (out_pop && !out_empty) begin
        if (pending_cmds.size() == 0) begin
          report($sformatf("command with no tick waiting: speed %0d turn %0d",
                           out_item.speed_out, out_item.turn_out));
        end else begin
          want = pending_cmds.pop_front();
          if (out_item.speed_out !== want.speed_out)
            report($sformatf("speed_out got %0d expected %0d",
                             out_item.speed_out, want.speed_out));
          if (out_item.turn_out !== want.turn_out)
            report($sformatf("turn_out got %0d expected %0d",
                             out_item.turn_out, want.turn_out));
        end
      end
      pending = pending_cmds.size();
    end
  end

endmodule

FILE: dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives control ticks into the speed profile slew limiter, directed first and
// then in random bursts, pops commands under a shifting stall pattern and
// reprograms the limits and gains between phases, extremes included. The
// command checker predicts and compares; this module reports the verdict.
// ----------------------------------------------------------------------------
module tb_top;
  import spsl_pkg::*;

  logic                   clk;
  logic                   rst_n     = 1'b0;
  logic                   in_push   = 1'b0;
  in_item_t               in_item   = '0;
  logic                   in_full;
  logic                   out_empty;
  logic                   out_pop   = 1'b0;
  out_item_t              out_item;
  logic                   cfg_we    = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
  int                     err_count;
  int                     pending;

  int quiet_cycles = 0;
  int burst_left   = 0;
  int stall_left   = 0;
  int pop_mode     = 0;
  int pop_cycle    = 0;

  speed_profile_slew_limiter uut (.*);
  spsl_command_checker       chk (.*);

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_push && !in_full) || (out_pop && !out_empty)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= 2000) begin
        $display("tb_top: errors");
        $finish;
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      pop_cycle++;
      if (pop_cycle % 97 == 0) pop_mode = $urandom_range(0, 3);
      if (stall_left > 0) begin
        stall_left--;
        out_pop <= 1'b0;
      end else begin
        out_pop <= 1'b1;
        case (pop_mode)
          1: stall_left = $urandom_range(0, 1);
          2: if ($urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 24);
          3: stall_left = $urandom_range(0, 3);
          default: ;
        endcase
      end
    end
  end

  task automatic send_tick(input in_item_t tick);
    @(negedge clk);
    in_push <= 1'b1;
    in_item <= tick;
    @(posedge clk);
    while (in_full) @(posedge clk);
  endtask

  task automatic tick(input int rs, input int rt, input bit seen,
                      input int c, input int l, input int h);
    in_item_t t;
    t.req_speed      = rs[15:0];
    t.req_turn       = rt[15:0];
    t.line_seen      = seen;
    t.curvature      = c[15:0];
    t.lateral_offset = l[15:0];
    t.heading_offset = h[15:0];
    send_tick(t);
  endtask

  task automatic pace();
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        @(negedge clk);
        in_push <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
  endtask

  task automatic settle();
    @(negedge clk);
    in_push <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic program_limits(input cfg_t c);
    settle();
    write_reg(CFG_SPEED_MAX,    {1'($urandom_range(0, 1)), c.speed_max});
    write_reg(CFG_SPEED_MIN,    {1'($urandom_range(0, 1)), c.speed_min});
    write_reg(CFG_ACCEL_STEP,   {1'($urandom_range(0, 1)), c.accel_step});
    write_reg(CFG_DECEL_STEP,   {1'($urandom_range(0, 1)), c.decel_step});
    write_reg(CFG_TURN_STEP,    {1'($urandom_range(0, 1)), c.turn_step});
    write_reg(CFG_CURVE_GAIN,   c.curve_gain);
    write_reg(CFG_OFFSET_GAIN,  c.offset_gain);
    write_reg(CFG_HEADING_GAIN, c.heading_gain);
  endtask

  function automatic logic [15:0] pick_limit(input int w);
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return 16'((1 << w) - 1);
      2, 3:    return 16'($urandom_range(0, 4096));
      default: return 16'($urandom_range(0, (1 << w) - 1));
    endcase
  endfunction

  function automatic cfg_t limits_for(input int ph);
    cfg_t c;
    c.speed_max    = 15'(pick_limit(15));
    c.speed_min    = 15'(pick_limit(15));
    c.accel_step   = 15'(pick_limit(15));
    c.decel_step   = 15'(pick_limit(15));
    c.turn_step    = 15'(pick_limit(15));
    c.curve_gain   = pick_limit(16);
    c.offset_gain  = pick_limit(16);
    c.heading_gain = pick_limit(16);
    case (ph)
      1: c = '0;
      2: c = '1;
      3: begin
        c.speed_max = 15'd1000;
        c.speed_min = 15'd5000;
      end
      4: begin
        c.speed_max  = 15'd30000;
        c.speed_min  = 15'd0;
        c.accel_step = 15'd32767;
        c.turn_step  = 15'd32767;
      end
      5: begin
        c.speed_max  = 15'd500;
        c.decel_step = 15'd7;
      end
      default: ;
    endcase
    return c;
  endfunction

  function automatic in_item_t random_tick(input in_item_t prev);
    in_item_t t;
    t = prev;
    if ($urandom_range(0, 9) < 3) begin
      case ($urandom_range(0, 9))
        0:       t.req_speed = 16'($urandom);
        1:       t.req_speed = 16'(-$urandom_range(0, 32768));
        2:       t.req_speed = '0;
        3, 4:    t.req_speed = 16'($urandom_range(1, 32767));
        default: t.req_speed = 16'($urandom_range(1, 3000));
      endcase
      case ($urandom_range(0, 9))
        0:       t.req_turn = 16'($urandom);
        1:       t.req_turn = 16'($urandom_range(0, 82) - 41);
        default: t.req_turn = 16'($urandom_range(0, 8000) - 4000);
      endcase
    end
    t.line_seen      = ($urandom_range(0, 3) != 0);
    t.curvature      = ($urandom_range(0, 4) == 0) ? 16'($urandom)
                                                   : 16'($urandom_range(0, 2000) - 1000);
    t.lateral_offset = ($urandom_range(0, 4) == 0) ? 16'($urandom)
                                                   : 16'($urandom_range(0, 2000) - 1000);
    t.heading_offset = ($urandom_range(0, 4) == 0) ? 16'($urandom)
                                                   : 16'($urandom_range(0, 2000) - 1000);
    return t;
  endfunction

  initial begin
    in_item_t last;
    last = '0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    tick(32767, 0, 0, 0, 0, 0);
    tick(32767, 32767, 0, 0, 0, 0);
    tick(32767, 32767, 1, -32768, 32767, -32768);
    tick(32767, -32768, 1, 100, -100, 50);
    tick(1, 0, 0, 0, 0, 0);
    tick(300, 20, 1, 10, 10, 10);
    tick(0, 40, 0, 0, 0, 0);
    tick(0, -41, 0, 0, 0, 0);
    tick(-32768, 41, 1, 0, 0, 0);
    tick(-1, -40, 0, 0, 0, 0);
    tick(2048, 0, 0, 0, 0, 0);
    tick(2048, 0, 0, 0, 0, 0);
    tick(32767, 0, 1, 32767, 0, 0);
    tick(500, 164, 1, 0, -32768, 0);
    tick(500, -164, 1, 0, 0, 32767);
    tick(0, 0, 1, -32768, -32768, -32768);
    tick(1500, 4000, 0, 0, 0, 0);
    tick(1500, 4000, 0, 0, 0, 0);

    for (int ph = 0; ph < 11; ph++) begin
      if (ph > 0) program_limits(limits_for(ph));
      for (int n = 0; n < 132; n++) begin
        pace();
        last = random_tick(last);
        send_tick(last);
      end
    end

    @(negedge clk);
    in_push <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (err_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/spsl_pkg.sv
rtl/spsl_queue.sv
rtl/spsl_front.sv
rtl/spsl_back.sv
rtl/speed_profile_slew_limiter.sv
dv/spsl_command_checker.sv
dv/tb_top.sv
